[src/bpc_pkg.sv]
// bpc_pkg: shared types and constants for the button press classifier
// no dependencies; used by button_press_classifier and its testbench
package bpc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned REG_IDX_W = 3;

  typedef logic [TIME_W-1:0] ms_t;

  // register index, byte address is 4 * index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PRESSED_LEVEL = 3'd0,
    REG_REJECT_MS     = 3'd1,
    REG_DOUBLE_MS     = 3'd2,
    REG_LONG_MS       = 3'd3,
    REG_RESTART_MS    = 3'd4
  } reg_idx_t;

  typedef enum logic {
    CMD_PIN_EVENT = 1'b0,
    CMD_POLL      = 1'b1
  } cmd_t;

  localparam ms_t RST_REJECT_MS  = 32'd50;
  localparam ms_t RST_DOUBLE_MS  = 32'd500;
  localparam ms_t RST_LONG_MS    = 32'd1000;
  localparam ms_t RST_RESTART_MS = 32'd10000;

  // status flags, msb first
  typedef struct packed {
    logic press_ended;
    logic start_release;
    logic double_press;
    logic start_double_press;
    logic pressed_long;
    logic start_long_press;
    logic pressed;
    logic start_press;
  } flags_t;

endpackage

[src/button_press_classifier.sv]
// button_press_classifier: top level, classifies presses of one button
// depends on bpc_pkg
// a poll word's result word is registered and shows in the cycle after the poll is accepted
// throughput: one word per cycle; pin events and polls update the state registers
// in the same cycle they are accepted, so the next word sees the new state
// input stalls only while the result register is full and stalled
// reset (rst, synchronous): state and flags cleared, registers at their defaults
module button_press_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic                          pin_level,
  input  logic [31:0]                   now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          start_press,
  output logic                          pressed,
  output logic                          start_long_press,
  output logic                          pressed_long,
  output logic                          start_double_press,
  output logic                          double_press,
  output logic                          start_release,
  output logic                          press_ended,
  output logic [31:0]                   press_duration,
  output logic                          restart_request,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [bpc_pkg::DATA_W-1:0]    pwdata,
  output logic [bpc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic          pressed_level;
  bpc_pkg::ms_t  reject_ms;
  bpc_pkg::ms_t  double_press_ms;
  bpc_pkg::ms_t  long_press_ms;
  bpc_pkg::ms_t  restart_ms;

  bpc_pkg::ms_t  press_start_time, press_start_time_next;
  bpc_pkg::ms_t  last_release_time, last_release_time_next;
  bpc_pkg::ms_t  held_time, held_time_next;
  bpc_pkg::flags_t status_flags, status_flags_next;
  logic          long_reported, long_reported_next;
  logic          release_reported, release_reported_next;

  bpc_pkg::flags_t snap;
  bpc_pkg::ms_t  dur;
  logic          restart;

  bpc_pkg::flags_t out_flags;
  logic          out_valid_next;

  bpc_pkg::ms_t  since_start;
  bpc_pkg::ms_t  gap;
  bpc_pkg::ms_t  held_poll;
  logic          is_long;
  logic          accept;
  logic          cfg_write;
  bpc_pkg::reg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = bpc_pkg::reg_idx_t'(paddr[bpc_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_level   <= 1'b1;
      reject_ms       <= bpc_pkg::RST_REJECT_MS;
      double_press_ms <= bpc_pkg::RST_DOUBLE_MS;
      long_press_ms   <= bpc_pkg::RST_LONG_MS;
      restart_ms      <= bpc_pkg::RST_RESTART_MS;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        bpc_pkg::REG_PRESSED_LEVEL: pressed_level   <= pwdata[0];
        bpc_pkg::REG_REJECT_MS:     reject_ms       <= pwdata;
        bpc_pkg::REG_DOUBLE_MS:     double_press_ms <= pwdata;
        bpc_pkg::REG_LONG_MS:       long_press_ms   <= pwdata;
        bpc_pkg::REG_RESTART_MS:    restart_ms      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bpc_pkg::REG_PRESSED_LEVEL: prdata = {{(bpc_pkg::DATA_W-1){1'b0}}, pressed_level};
      bpc_pkg::REG_REJECT_MS:     prdata = reject_ms;
      bpc_pkg::REG_DOUBLE_MS:     prdata = double_press_ms;
      bpc_pkg::REG_LONG_MS:       prdata = long_press_ms;
      bpc_pkg::REG_RESTART_MS:    prdata = restart_ms;
      default:                    prdata = '0;
    endcase
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign since_start = now_ms - press_start_time;
  assign gap         = now_ms - last_release_time;
  assign held_poll   = status_flags.press_ended ? held_time : since_start;
  assign is_long     = held_poll > long_press_ms;

  always_comb begin
    press_start_time_next  = press_start_time;
    last_release_time_next = last_release_time;
    held_time_next         = held_time;
    status_flags_next      = status_flags;
    long_reported_next     = long_reported;
    release_reported_next  = release_reported;
    snap    = status_flags;
    dur     = held_poll;
    restart = 1'b0;
    if (accept) begin
      if (bpc_pkg::cmd_t'(command) == bpc_pkg::CMD_PIN_EVENT) begin
        if (pin_level == pressed_level) begin
          held_time_next                = '0;
          status_flags_next.pressed     = 1'b1;
          status_flags_next.press_ended = 1'b0;
          long_reported_next            = 1'b0;
          release_reported_next         = 1'b0;
          if (gap > reject_ms) begin
            press_start_time_next         = now_ms;
            status_flags_next.start_press = 1'b1;
            if (gap < double_press_ms) begin
              status_flags_next.start_double_press = 1'b1;
              status_flags_next.double_press       = 1'b1;
            end
          end
        end else if (!(since_start > restart_ms)) begin
          status_flags_next.press_ended = 1'b1;
          held_time_next                = since_start;
          last_release_time_next        = now_ms;
        end
      end else begin
        // poll: build the reported snapshot first
        snap = status_flags;
        if (is_long) begin
          restart           = held_poll > restart_ms;
          snap.pressed_long = 1'b1;
          if (!long_reported) begin
            snap.start_long_press = 1'b1;
          end
          long_reported_next = 1'b1;
        end else begin
          snap.pressed_long = 1'b0;
        end
        if (snap.press_ended) begin
          snap.pressed      = 1'b0;
          snap.double_press = 1'b0;
        end
        status_flags_next                    = snap;
        status_flags_next.start_press        = 1'b0;
        status_flags_next.start_long_press   = 1'b0;
        status_flags_next.start_release      = 1'b0;
        status_flags_next.start_double_press = 1'b0;
        held_time_next = held_poll;
        if (snap.press_ended) begin
          held_time_next = '0;
          if (!release_reported) begin
            release_reported_next           = 1'b1;
            status_flags_next.start_release = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_start_time  <= '0;
      last_release_time <= '0;
      held_time         <= '0;
      status_flags      <= '0;
      long_reported     <= 1'b0;
      release_reported  <= 1'b0;
    end else begin
      press_start_time  <= press_start_time_next;
      last_release_time <= last_release_time_next;
      held_time         <= held_time_next;
      status_flags      <= status_flags_next;
      long_reported     <= long_reported_next;
      release_reported  <= release_reported_next;
    end
  end

  // result register
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (accept && bpc_pkg::cmd_t'(command) == bpc_pkg::CMD_POLL) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && bpc_pkg::cmd_t'(command) == bpc_pkg::CMD_POLL) begin
      out_flags       <= snap;
      press_duration  <= dur;
      restart_request <= restart;
    end
  end

  assign start_press        = out_flags.start_press;
  assign pressed            = out_flags.pressed;
  assign start_long_press   = out_flags.start_long_press;
  assign pressed_long       = out_flags.pressed_long;
  assign start_double_press = out_flags.start_double_press;
  assign double_press       = out_flags.double_press;
  assign start_release      = out_flags.start_release;
  assign press_ended        = out_flags.press_ended;

endmodule

[src/bpc_checker.sv]
// bpc_checker: port-level assertions for button_press_classifier
// watches the handshake and result ports; bound to the top level at the end of this file
module bpc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       start_long_press,
  input logic                       pressed_long,
  input logic                       pressed,
  input logic                       double_press,
  input logic                       press_ended,
  input logic [31:0]                press_duration,
  input logic                       restart_request
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(press_duration))
    else $error("result word changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result register full and stalled");

  a_restart_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && restart_request |-> pressed_long)
    else $error("restart request without long press");

  a_start_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_long_press |-> pressed_long)
    else $error("long press one-shot without long press");

  a_ended: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_ended |-> !pressed && !double_press)
    else $error("released press still reported held");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

[tb/button_press_classifier_tb.sv]
// button_press_classifier_tb: self-checking bench for the button press classifier
// drives pin events and polls with bursty timing, predicts every poll word and compares it
// depends on bpc_pkg and button_press_classifier
module button_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int NUM_DIRECTED = 23;
  localparam int NUM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 125;

  typedef struct packed {
    bpc_pkg::flags_t flags;
    bpc_pkg::ms_t    duration;
    logic            restart;
  } poll_result_t;

  typedef struct packed {
    bpc_pkg::cmd_t cmd;
    logic          level;
    bpc_pkg::ms_t  stamp;
    logic          typed;
    poll_result_t  want;
  } stim_row_t;

  typedef struct packed {
    logic         level;
    bpc_pkg::ms_t reject;
    bpc_pkg::ms_t dbl;
    bpc_pkg::ms_t lng;
    bpc_pkg::ms_t restart;
  } cfg_set_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{bpc_pkg::CMD_POLL,      1'b0, 32'd0,          1'b1, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b1, 32'hFFFF_FFFF,  1'b1, {8'h0C, 32'hFFFF_FFFF, 1'b1}},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b1, 32'd100,        1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b0, 32'd200,        1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b0, 32'd1500,       1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b1, 32'd1600,       1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b0, 32'd1700,       1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b1, 32'd1520,       1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b0, 32'd1530,       1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b0, 32'd20000,      1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b0, 32'd20001,      1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b0, 32'd20002,      1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b1, 32'd30000,      1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b1, 32'd30010,      1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b1, 32'd30020,      1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b0, 32'd30100,      1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b0, 32'd30200,      1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b0, 32'd30300,      1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b1, 32'hFFFF_FFF0,  1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b0, 32'd10,         1'b0, 41'h0},
    '{bpc_pkg::CMD_PIN_EVENT, 1'b0, 32'd20,         1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b0, 32'hFFFF_FFFF,  1'b0, 41'h0},
    '{bpc_pkg::CMD_POLL,      1'b1, 32'd0,          1'b0, 41'h0}
  };

  localparam cfg_set_t PHASES [NUM_PHASES] = '{
    '{1'b1, bpc_pkg::RST_REJECT_MS, bpc_pkg::RST_DOUBLE_MS, bpc_pkg::RST_LONG_MS,
      bpc_pkg::RST_RESTART_MS},
    '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{1'b0, 32'd20, 32'd300, 32'd700, 32'd2000},
    '{1'b1, 32'd5, 32'd40, 32'd100, 32'd150},
    '{1'b0, 32'd100, 32'd50, 32'd3000, 32'd500}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       command = 1'b0;
  logic                       pin_level = 1'b0;
  logic [31:0]                now_ms = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       start_press;
  logic                       pressed;
  logic                       start_long_press;
  logic                       pressed_long;
  logic                       start_double_press;
  logic                       double_press;
  logic                       start_release;
  logic                       press_ended;
  logic [31:0]                press_duration;
  logic                       restart_request;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [bpc_pkg::ADDR_W-1:0] paddr = '0;
  logic [bpc_pkg::DATA_W-1:0] pwdata = '0;
  logic [bpc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // predictor copy of configuration and state
  logic            cfg_level = 1'b1;
  bpc_pkg::ms_t    cfg_reject = bpc_pkg::RST_REJECT_MS;
  bpc_pkg::ms_t    cfg_double = bpc_pkg::RST_DOUBLE_MS;
  bpc_pkg::ms_t    cfg_long = bpc_pkg::RST_LONG_MS;
  bpc_pkg::ms_t    cfg_restart = bpc_pkg::RST_RESTART_MS;
  bpc_pkg::ms_t    press_t0 = '0;
  bpc_pkg::ms_t    release_t = '0;
  bpc_pkg::ms_t    held = '0;
  bpc_pkg::flags_t st = '0;
  logic            long_done = 1'b0;
  logic            rel_done = 1'b0;

  poll_result_t pending_polls[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  logic         drv_typed = 1'b0;
  poll_result_t drv_want = '0;
  int           burst_left = 0;
  int           gap_cnt = 0;
  rx_mode_t     rx_mode = RX_FREE;
  int           rx_left = 0;

  button_press_classifier u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit classify_word(input bpc_pkg::cmd_t c, input logic lvl,
                                       input bpc_pkg::ms_t t, output poll_result_t r);
    bpc_pkg::ms_t gap;
    r = '0;
    if (c == bpc_pkg::CMD_PIN_EVENT) begin
      if (lvl == cfg_level) begin
        gap = t - release_t;
        held = '0;
        st.pressed = 1'b1;
        st.press_ended = 1'b0;
        long_done = 1'b0;
        rel_done = 1'b0;
        if (gap > cfg_reject) begin
          press_t0 = t;
          st.start_press = 1'b1;
          if (gap < cfg_double) begin
            st.start_double_press = 1'b1;
            st.double_press = 1'b1;
          end
        end
      end else if (bpc_pkg::ms_t'(t - press_t0) <= cfg_restart) begin
        st.press_ended = 1'b1;
        held = t - press_t0;
        release_t = t;
      end
      return 1'b0;
    end
    if (!st.press_ended) held = t - press_t0;
    if (held > cfg_long) begin
      r.restart = held > cfg_restart;
      st.pressed_long = 1'b1;
      if (!long_done) begin
        st.start_long_press = 1'b1;
        long_done = 1'b1;
      end
    end else begin
      st.pressed_long = 1'b0;
    end
    if (st.press_ended) begin
      st.pressed = 1'b0;
      st.double_press = 1'b0;
    end
    r.flags = st;
    r.duration = held;
    st.start_press = 1'b0;
    st.start_long_press = 1'b0;
    st.start_release = 1'b0;
    st.start_double_press = 1'b0;
    if (st.press_ended) begin
      held = '0;
      if (!rel_done) begin
        rel_done = 1'b1;
        st.start_release = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic void cmp(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    poll_result_t calc;
    poll_result_t want;
    bit           busy;
    if (!rst) begin
      busy = 1'b0;
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (pending_polls.size() == 0) begin
          $error("result word with no poll pending");
          mismatches++;
        end else begin
          want = pending_polls.pop_front();
          cmp("start_press", 32'(want.flags.start_press), 32'(start_press));
          cmp("pressed", 32'(want.flags.pressed), 32'(pressed));
          cmp("start_long_press", 32'(want.flags.start_long_press), 32'(start_long_press));
          cmp("pressed_long", 32'(want.flags.pressed_long), 32'(pressed_long));
          cmp("start_double_press", 32'(want.flags.start_double_press),
              32'(start_double_press));
          cmp("double_press", 32'(want.flags.double_press), 32'(double_press));
          cmp("start_release", 32'(want.flags.start_release), 32'(start_release));
          cmp("press_ended", 32'(want.flags.press_ended), 32'(press_ended));
          cmp("press_duration", want.duration, press_duration);
          cmp("restart_request", 32'(want.restart), 32'(restart_request));
        end
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        if (classify_word(bpc_pkg::cmd_t'(command), pin_level, now_ms, calc))
          pending_polls.push_back(drv_typed ? drv_want : calc);
      end
      if (psel && penable && pwrite && pready) busy = 1'b1;
      if (busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin : rx_stall
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE: out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      RX_PERIODIC: out_stall <= (rx_left % 4 == 0);
      default: out_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  task automatic send_word(input bpc_pkg::cmd_t c, input logic l, input bpc_pkg::ms_t t,
                           input logic typed, input poll_result_t want);
    if (gap_cnt > 0) begin
      in_valid <= 1'b0;
      repeat (gap_cnt) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    pin_level <= l;
    now_ms <= t;
    drv_typed <= typed;
    drv_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_cnt = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
    end else begin
      burst_left--;
      gap_cnt = 0;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_polls.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input bpc_pkg::reg_idx_t idx,
                           input logic [bpc_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bpc_pkg::REG_PRESSED_LEVEL: cfg_level = val[0];
      bpc_pkg::REG_REJECT_MS: cfg_reject = val;
      bpc_pkg::REG_DOUBLE_MS: cfg_double = val;
      bpc_pkg::REG_LONG_MS: cfg_long = val;
      default: cfg_restart = val;
    endcase
  endtask

  // a stamp just below, at or just above base plus one of two thresholds or a short span
  function automatic bpc_pkg::ms_t near(input bpc_pkg::ms_t base, input bpc_pkg::ms_t a,
                                        input bpc_pkg::ms_t b);
    bpc_pkg::ms_t thr;
    case ($urandom_range(0, 2))
      0: thr = a;
      1: thr = b;
      default: thr = $urandom_range(0, 3000);
    endcase
    return base + thr + bpc_pkg::ms_t'($urandom_range(0, 2)) - 1;
  endfunction

  task automatic next_word(output bpc_pkg::cmd_t c, output logic l, output bpc_pkg::ms_t t);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      c = bpc_pkg::cmd_t'($urandom_range(0, 1));
      l = 1'($urandom_range(0, 1));
      t = $urandom;
    end else if (r < 45) begin
      c = bpc_pkg::CMD_PIN_EVENT;
      if (st.pressed && !st.press_ended) begin
        l = ~cfg_level;
        t = near(press_t0, cfg_long, cfg_restart);
      end else begin
        l = cfg_level;
        t = near(release_t, cfg_reject, cfg_double);
      end
      if ($urandom_range(0, 9) == 0) l = ~l;
    end else begin
      c = bpc_pkg::CMD_POLL;
      l = 1'($urandom_range(0, 1));
      t = near(press_t0, cfg_long, cfg_restart);
    end
  endtask

  initial begin : stimulus
    bpc_pkg::cmd_t c;
    logic          l;
    bpc_pkg::ms_t  t;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_word(DIRECTED[i].cmd, DIRECTED[i].level, DIRECTED[i].stamp, DIRECTED[i].typed,
                DIRECTED[i].want);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      cfg_write(bpc_pkg::REG_PRESSED_LEVEL, bpc_pkg::DATA_W'(PHASES[p].level));
      cfg_write(bpc_pkg::REG_REJECT_MS, PHASES[p].reject);
      cfg_write(bpc_pkg::REG_DOUBLE_MS, PHASES[p].dbl);
      cfg_write(bpc_pkg::REG_LONG_MS, PHASES[p].lng);
      cfg_write(bpc_pkg::REG_RESTART_MS, PHASES[p].restart);
      repeat (WORDS_PER_PHASE) begin
        next_word(c, l, t);
        send_word(c, l, t, 1'b0, '0);
      end
    end
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
src/bpc_pkg.sv
src/button_press_classifier.sv
src/bpc_checker.sv
tb/button_press_classifier_tb.sv
